FILE: rtl/assert_macros.svh
// Assertion macros used by the checker in rtl/lzbe_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

FILE: rtl/lzbe_pkg.sv
package lzbe_pkg;

    // Field widths fixed by the stream format.
    localparam int BYTE_W   = 8;
    localparam int PREFIX_W = 12;

    // Default dictionary size and the number of cells in the chain.
    localparam int DICT_ENTRIES_DEF = 4096;
    localparam int CELLS            = 16;
    localparam int CELL_W           = $clog2(CELLS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } lzbe_state_t;

    // Priority result handed from one cell to the next.
    typedef struct packed {
        logic              found;
        logic [CELL_W-1:0] slot;
    } lzbe_chain_t;

endpackage

FILE: rtl/lzbe_cell.sv
module lzbe_cell
    import lzbe_pkg::*;
#(
    parameter int CELL_ID = 0,
    parameter int IW      = 12,
    parameter int RW      = 8,
    parameter int CNTW    = 13
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [RW-1:0]     wr_row,
    input  logic [IW-1:0]     wr_parent,
    input  logic [BYTE_W-1:0] wr_byte,
    input  logic [RW-1:0]     rd_row,
    input  logic [RW-1:0]     cmp_row,
    input  logic [IW-1:0]     key_parent,
    input  logic [BYTE_W-1:0] key_byte,
    input  logic [CNTW-1:0]   entry_count,
    input  lzbe_chain_t       chain_in,
    output lzbe_chain_t       chain_out
);

    localparam int ROWS = 1 << RW;
    localparam logic [CELL_W-1:0] ID = CELL_W'(CELL_ID);

    logic [IW-1:0]     parent_mem [ROWS];
    logic [BYTE_W-1:0] byte_mem   [ROWS];
    logic [IW-1:0]     rd_parent_reg;
    logic [BYTE_W-1:0] rd_byte_reg;
    logic [RW+CELL_W-1:0] entry;
    logic              entry_ok;
    logic              match;

    // This cell's slice of the dictionary, with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            parent_mem[wr_row] <= wr_parent;
            byte_mem[wr_row]   <= wr_byte;
        end
        rd_parent_reg <= parent_mem[rd_row];
        rd_byte_reg   <= byte_mem[rd_row];
    end

    // Entry number of the word just read; only entries 1 .. count-1 are live.
    assign entry    = {cmp_row, ID};
    assign entry_ok = (entry != '0) && (32'(entry) < 32'(entry_count));
    assign match    = entry_ok && (rd_parent_reg == key_parent) && (rd_byte_reg == key_byte);

    // The lowest matching cell keeps priority along the chain.
    always_comb
    begin
        chain_out = chain_in;
        if (!chain_in.found && match)
        begin
            chain_out.found = 1'b1;
            chain_out.slot  = ID;
        end
    end

endmodule

FILE: rtl/lz78_byte_encoder.sv
// LZ78 byte encoder built as a chain of dictionary cells.
// Each byte is searched for before the next input beat is taken, over
// R = ceil(entry_count / 16) rows swept through the cell memories, one row a cycle;
// a hit ends the sweep early. A pair, on a miss or on the last byte, shows from an output register.
// Reset (rst_n low, asynchronous) empties the dictionary and clears the prefix.
module lz78_byte_encoder
    import lzbe_pkg::*;
#(
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                last_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PREFIX_W-1:0] prefix_index,
    output logic [BYTE_W-1:0]   symbol,
    output logic                stream_end
);

    localparam int IW    = $clog2(DICT_ENTRIES);
    localparam int CNTW  = $clog2(DICT_ENTRIES + 1);
    localparam int ROWS  = (DICT_ENTRIES + CELLS - 1) / CELLS;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

    lzbe_state_t state_reg, state_next;

    logic [CNTW-1:0]   count_reg, count_next;
    logic [IW-1:0]     prefix_reg, prefix_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic [RW:0]       row_reg, row_next;
    logic [RW-1:0]     cmp_row_reg;
    logic              cmp_valid_reg, cmp_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic [PREFIX_W-1:0] out_prefix_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_end_reg;

    logic [CNTW-1:0]   count_m1;
    logic [RW:0]       last_row;
    logic              issue;
    logic              in_beat;
    logic              out_free;
    logic              hit;
    logic              miss;
    logic              do_emit;
    logic              do_add;
    logic [IW-1:0]     hit_entry;
    logic [RW-1:0]     wr_row;

    lzbe_chain_t chain [CELLS+1];

    assign in_beat  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign count_m1 = count_reg - CNTW'(1);
    assign last_row = (RW+1)'(count_m1 >> CELL_W);
    assign issue    = (state_reg == ST_SEARCH) && (row_reg <= last_row);
    assign hit      = (state_reg == ST_SEARCH) && cmp_valid_reg && chain[CELLS].found;
    assign miss     = (state_reg == ST_SEARCH) && cmp_valid_reg && !chain[CELLS].found
                      && ({1'b0, cmp_row_reg} == last_row);
    assign do_emit  = (state_reg == ST_EMIT) && out_free;
    assign do_add   = do_emit && (32'(count_reg) < DICT_ENTRIES);
    assign hit_entry = IW'({cmp_row_reg, chain[CELLS].slot});
    assign wr_row   = RW'(count_reg >> CELL_W);

    // Cell chain; the head of the chain has found nothing yet.
    assign chain[0] = '{found: 1'b0, slot: '0};

    for (genvar g = 0; g < CELLS; g++)
    begin : g_cell
        lzbe_cell #(
            .CELL_ID (g),
            .IW      (IW),
            .RW      (RW),
            .CNTW    (CNTW)
        ) u_cell (
            .clk         (clk),
            .wr_en       (do_add && (count_reg[CELL_W-1:0] == CELL_W'(g))),
            .wr_row      (wr_row),
            .wr_parent   (prefix_reg),
            .wr_byte     (byte_reg),
            .rd_row      (row_reg[RW-1:0]),
            .cmp_row     (cmp_row_reg),
            .key_parent  (prefix_reg),
            .key_byte    (byte_reg),
            .entry_count (count_reg),
            .chain_in    (chain[g]),
            .chain_out   (chain[g+1])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (hit && !last_reg)
                    state_next = ST_IDLE;
                else if (hit || miss)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath control per state.
    always_comb
    begin
        in_ready       = 1'b0;
        row_next       = row_reg;
        cmp_valid_next = 1'b0;
        prefix_next    = prefix_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                row_next = '0;
            end
            ST_SEARCH:
            begin
                cmp_valid_next = issue && !hit;
                if (issue)
                    row_next = row_reg + (RW+1)'(1);
                if (hit && !last_reg)
                    prefix_next = hit_entry;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    prefix_next    = '0;
                    if (do_add)
                        count_next = count_reg + CNTW'(1);
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= CNTW'(1);
            prefix_reg    <= '0;
            row_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            prefix_reg    <= prefix_next;
            row_reg       <= row_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
        cmp_row_reg <= row_reg[RW-1:0];
        if (do_emit)
        begin
            out_prefix_reg <= PREFIX_W'(prefix_reg);
            out_byte_reg   <= byte_reg;
            out_end_reg    <= last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign prefix_index = out_prefix_reg;
    assign symbol       = out_byte_reg;
    assign stream_end   = out_end_reg;

endmodule

FILE: rtl/lzbe_checker.sv
`include "assert_macros.svh"

module lzbe_checker
    import lzbe_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [PREFIX_W-1:0] prefix_index,
    input logic [BYTE_W-1:0]   symbol,
    input logic                stream_end
);

    // A stalled result beat stays put.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable({prefix_index, symbol, stream_end}))

    // One byte at a time: after a beat, the search keeps the input closed in the next cycle.
    `ASSERT_NEXT(a_in_busy, clk, rst_n, in_valid && in_ready, !in_ready)

    // A result beat on offer carries known values.
    `ASSERT_NOW(a_out_known, clk, rst_n, out_valid, !$isunknown({prefix_index, symbol, stream_end}))

endmodule

bind lz78_byte_encoder lzbe_checker u_lzbe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .prefix_index (prefix_index),
    .symbol       (symbol),
    .stream_end   (stream_end)
);

FILE: bench/lz78_pair_checker.sv
`timescale 1ns / 1ps

module lz78_pair_checker
    import lzbe_pkg::*;
#(
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                last_byte,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [PREFIX_W-1:0] prefix_index,
    input  logic [BYTE_W-1:0]   symbol,
    input  logic                stream_end,
    output int                  fail_count,
    output int                  pairs_pending,
    output int                  pairs_seen,
    output int                  entries_used
);

    localparam int PAIR_DEPTH = 64;

    typedef struct packed {
        logic [PREFIX_W-1:0] prefix;
        logic [BYTE_W-1:0]   sym;
        logic                fin;
    } lz_pair_t;

    // Shadow dictionary and match state.
    logic [PREFIX_W-1:0] phrase_parent [DICT_ENTRIES];
    logic [BYTE_W-1:0]   phrase_byte [DICT_ENTRIES];
    int                  phrase_count;
    logic [PREFIX_W-1:0] match_entry;

    // Expected pairs in order, kept in a ring.
    lz_pair_t            pair_fifo [PAIR_DEPTH];
    int                  pair_wr;
    int                  pair_rd;

    assign pairs_pending = pair_wr - pair_rd;
    assign entries_used  = phrase_count;

    // Encode one accepted byte into the shadow state.
    task automatic encode_byte(input logic [BYTE_W-1:0] b, input logic fin);
        int       hit;
        lz_pair_t p;
        hit = 0;
        for (int i = 1; i < phrase_count; i++)
        begin
            if (phrase_parent[i] == match_entry && phrase_byte[i] == b)
            begin
                hit = i;
                break;
            end
        end
        if (hit != 0 && !fin)
        begin
            match_entry = hit[PREFIX_W-1:0];
        end
        else
        begin
            p.prefix = match_entry;
            p.sym    = b;
            p.fin    = fin;
            pair_fifo[pair_wr % PAIR_DEPTH] = p;
            pair_wr++;
            if (phrase_count < DICT_ENTRIES)
            begin
                phrase_parent[phrase_count] = match_entry;
                phrase_byte[phrase_count]   = b;
                phrase_count++;
            end
            match_entry = '0;
        end
    endtask

    // Compare each output beat with the oldest expected pair.
    always @(posedge clk or negedge rst_n)
    begin
        lz_pair_t want;
        if (!rst_n)
        begin
            phrase_count = 1;
            match_entry  = '0;
            pair_wr      = 0;
            pair_rd      = 0;
            fail_count   = 0;
            pairs_seen   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                pairs_seen++;
                if (pair_wr == pair_rd)
                begin
                    $display("%0t: unexpected pair, expected none, got %0d/%0h/%0b",
                             $time, prefix_index, symbol, stream_end);
                    fail_count++;
                end
                else
                begin
                    want = pair_fifo[pair_rd % PAIR_DEPTH];
                    pair_rd++;
                    if (prefix_index !== want.prefix)
                    begin
                        $display("%0t: prefix_index expected %0d, got %0d",
                                 $time, want.prefix, prefix_index);
                        fail_count++;
                    end
                    if (symbol !== want.sym)
                    begin
                        $display("%0t: symbol expected %0h, got %0h",
                                 $time, want.sym, symbol);
                        fail_count++;
                    end
                    if (stream_end !== want.fin)
                    begin
                        $display("%0t: stream_end expected %0b, got %0b",
                                 $time, want.fin, stream_end);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                encode_byte(data_byte, last_byte);
            end
        end
    end

endmodule

FILE: bench/tb_lz78_byte_encoder.sv
`timescale 1ns / 1ps

module tb_lz78_byte_encoder;
    import lzbe_pkg::*;

    localparam int RANDOM_BYTES = 1400;
    localparam int STALL_LIMIT  = 20000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [BYTE_W-1:0]   data_byte;
    logic                last_byte;
    logic                out_valid;
    logic                out_ready;
    logic [PREFIX_W-1:0] prefix_index;
    logic [BYTE_W-1:0]   symbol;
    logic                stream_end;
    int                  fail_count;
    int                  pairs_pending;
    int                  pairs_seen;
    int                  entries_used;
    int                  bytes_sent;
    int                  quiet_cycles;
    bit                  calm_phase;
    logic [BYTE_W-1:0]   motif [8];

    lz78_byte_encoder dut (.*);

    lz78_pair_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Output side stalls in random bursts until the calm phase.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm_phase && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accepted beat.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Present one byte and hold it until accepted, with an optional gap first.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        if (!calm_phase && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic drain_pairs();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pairs_pending != 0) @(posedge clk);
    endtask

    initial
    begin
        int kind;
        int len;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = '0;
        last_byte  = 1'b0;
        calm_phase = 1'b0;
        bytes_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, repeated phrases, last byte on a known phrase.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);

        // Hold the sender until every pair is out.
        drain_pairs();

        // Random: mostly repeated motifs so phrases grow long, some noise.
        for (int i = 0; i < 8; i++) motif[i] = BYTE_W'($urandom);
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (bytes_sent > RANDOM_BYTES - 150) calm_phase = 1'b1;
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 40);
            for (int j = 0; j < len; j++)
            begin
                if (kind < 7)
                    send_byte(motif[$urandom_range(0, 3 + kind % 4)], 1'b0);
                else
                    send_byte(BYTE_W'($urandom), 1'b0);
            end
            if ($urandom_range(0, 3) == 0)
                send_byte(BYTE_W'($urandom), 1'b1);
        end
        send_byte(motif[0], 1'b1);

        // Wait for the remaining pairs, then let the block settle.
        drain_pairs();
        repeat (20) @(posedge clk);
        $display("Sent %0d bytes, checked %0d pairs, dictionary reached %0d entries.",
                 bytes_sent, pairs_seen, entries_used);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/lzbe_pkg.sv
rtl/lzbe_cell.sv
rtl/lz78_byte_encoder.sv
rtl/lzbe_checker.sv
bench/lz78_pair_checker.sv
bench/tb_lz78_byte_encoder.sv
